@@ sv/ctpd_pkg.sv @@
// ctpd_pkg: shared types, constants and tables for cartesian_to_polar_degrees
// no dependencies
`timescale 1ns / 1ps
package ctpd_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 20;
  localparam int DW = 64;
  localparam int ZW = 34;
  localparam int SQW = 64;
  localparam int RSTEPS = 32;
  localparam logic [ZW-1:0] PI_Q30 = 34'd3373259426;
  localparam logic [29:0] DEG_Q24 = 30'd961263669;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        radius;
    logic signed [19:0] angle_radians;
    logic [8:0]         angle_degrees;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic            zero;
    logic            xneg;
    logic [31:0]     ax;
    logic signed [31:0] y;
    logic [SQW-1:0]  sq;
  } cls_item_t;

  function automatic logic [ZW-1:0] atan_q30(input logic [5:0] i);
    logic [ZW-1:0] v;
    begin
      case (i)
        6'd0: v = 34'd843314857;
        6'd1: v = 34'd497837829;
        6'd2: v = 34'd263043837;
        6'd3: v = 34'd133525159;
        6'd4: v = 34'd67021687;
        6'd5: v = 34'd33543516;
        6'd6: v = 34'd16775851;
        6'd7: v = 34'd8388437;
        6'd8: v = 34'd4194283;
        6'd9: v = 34'd2097149;
        6'd10: v = 34'd1048576;
        default: v = (i <= 6'd30) ? (34'd1 << (6'd30 - i)) : 34'd0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ sv/cartesian_to_polar_degrees.sv @@
// cartesian_to_polar_degrees: top level, front classifier, queue and cordic back end
// depends on ctpd_pkg, ctpd_front, ctpd_queue, ctpd_back
//
// usage:
//   a request (x_coord, y_coord, signed q16.16) is taken when start is high
//   and busy is low. one result (radius q16.16, angle_radians q3.16,
//   angle_degrees 0..359) appears for one cycle with done high.
// throughput: one request per cycle; the back end is a fully unrolled
//   pipeline with at most one cordic rotation and one root digit per stage.
// path: a request passes 2 front registers (the first loads at the accepting
//   edge), the queue write, the pipeline stages and 2 finishing registers
//   before done is high.
// reset: rst clears all valid flags and the queue; no request is in flight.
// the receiver cannot stall, so the back end always drains; busy stays low
//   in steady operation and the queue only absorbs the front/back handoff.
`timescale 1ns / 1ps
module cartesian_to_polar_degrees #(
  parameter int ANGLE_ITERATIONS = ctpd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ctpd_pkg::in_item_t  request,
  output logic                busy,
  output logic                done,
  output ctpd_pkg::out_item_t result
);

  logic                f_valid;
  ctpd_pkg::cls_item_t f_item;
  logic                f_ready;
  logic                q_valid;
  ctpd_pkg::cls_item_t q_item;
  logic                b_ready;

  ctpd_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(request), .busy(busy),
    .cls_valid(f_valid), .cls_item(f_item), .cls_ready(f_ready)
  );

  ctpd_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_item(f_item), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_item(q_item), .rd_ready(b_ready)
  );

  ctpd_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item), .in_ready(b_ready),
    .done(done), .result(result)
  );

endmodule

@@ sv/ctpd_front.sv @@
// ctpd_front: accepts vectors, squares components and classifies them
// depends on ctpd_pkg
`timescale 1ns / 1ps
module ctpd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  ctpd_pkg::in_item_t     in_item,
  output logic                   busy,
  output logic                   cls_valid,
  output ctpd_pkg::cls_item_t    cls_item,
  input  logic                   cls_ready
);

  localparam int SQW_L = ctpd_pkg::SQW;
  logic                 s1_valid;
  logic signed [31:0]   s1_x;
  logic signed [31:0]   s1_y;
  logic [SQW_L-1:0]     xx;
  logic [SQW_L-1:0]     yy;
  logic                 s2_valid;
  ctpd_pkg::cls_item_t  s2_item;
  logic                 adv;
  logic [31:0]          ax1;

  assign adv = !s2_valid || cls_ready;
  assign busy = s1_valid && !adv;
  assign cls_valid = s2_valid;
  assign cls_item = s2_item;
  assign ax1 = s1_x[31] ? (32'd0 - s1_x) : s1_x;
  assign xx = SQW_L'(64'(s1_x) * 64'(s1_x));
  assign yy = SQW_L'(64'(s1_y) * 64'(s1_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv) s2_valid <= s1_valid;
      if (!busy) s1_valid <= start;
    end
    if (start && !busy) begin
      s1_x <= in_item.x_coord;
      s1_y <= in_item.y_coord;
    end
    if (adv) begin
      s2_item.sq   <= xx + yy;
      s2_item.zero <= (s1_x == 32'sd0) && (s1_y == 32'sd0);
      s2_item.xneg <= s1_x[31];
      s2_item.ax   <= ax1;
      s2_item.y    <= s1_y;
    end
  end

endmodule

@@ sv/ctpd_queue.sv @@
// ctpd_queue: short fifo between front and back
// depends on ctpd_pkg
`timescale 1ns / 1ps
module ctpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  input  ctpd_pkg::cls_item_t wr_item,
  output logic                wr_ready,
  output logic                rd_valid,
  output ctpd_pkg::cls_item_t rd_item,
  input  logic                rd_ready
);

  localparam int AW = $clog2(ctpd_pkg::QDEPTH);
  ctpd_pkg::cls_item_t mem [ctpd_pkg::QDEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          wr;
  logic          rd;

  assign wr_ready = (cnt != (AW+1)'(ctpd_pkg::QDEPTH)) || rd_ready;
  assign rd_valid = cnt != '0;
  assign rd_item = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp] <= wr_item;
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt == (AW+1)'(ctpd_pkg::QDEPTH) && !rd_ready |-> !wr)
    else $error("queue overflow");
  a_cnt_rng: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(ctpd_pkg::QDEPTH))
    else $error("queue count out of range");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> !rd)
    else $error("read from empty queue");
`endif

endmodule

@@ sv/ctpd_back.sv @@
// ctpd_back: pipelined cordic vectoring, square root and degree conversion
// depends on ctpd_pkg
`timescale 1ns / 1ps
module ctpd_back #(
  parameter int ANGLE_ITERATIONS = ctpd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ctpd_pkg::cls_item_t in_item,
  output logic                in_ready,
  output logic                done,
  output ctpd_pkg::out_item_t result
);

  localparam int N  = ctpd_pkg::RSTEPS > ANGLE_ITERATIONS ?
                      ctpd_pkg::RSTEPS : ANGLE_ITERATIONS;
  localparam int DW = ctpd_pkg::DW;
  localparam int ZW = ctpd_pkg::ZW;

  // pipeline carries cordic and sqrt state side by side
  logic                 v   [N+1];
  logic                 zr  [N+1];
  logic                 xn  [N+1];
  logic signed [DW-1:0] cx  [N+1];
  logic signed [DW-1:0] cy  [N+1];
  logic signed [ZW-1:0] z   [N+1];
  logic [63:0]          rs  [N+1];
  logic [63:0]          rr  [N+1];

  assign in_ready = 1'b1;

  always_comb begin
    v[0]  = in_valid;
    zr[0] = in_item.zero;
    xn[0] = in_item.xneg;
    cx[0] = DW'({in_item.ax, 28'd0});
    cy[0] = DW'(signed'({in_item.y, 28'd0}));
    z[0]  = '0;
    rs[0] = 64'(in_item.sq);
    rr[0] = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [63:0] bitv;
    logic [63:0] t;
    assign bitv = 64'd1 << (62 - 2*i);
    assign t = rr[i] + bitv;
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      zr[i+1] <= zr[i];
      xn[i+1] <= xn[i];
      if (i < ANGLE_ITERATIONS) begin
        if (!cy[i][DW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          z[i+1]  <= z[i] + signed'(ctpd_pkg::atan_q30(6'(i)));
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          z[i+1]  <= z[i] - signed'(ctpd_pkg::atan_q30(6'(i)));
        end
      end else begin
        cx[i+1] <= cx[i];
        cy[i+1] <= cy[i];
        z[i+1]  <= z[i];
      end
      if (i < ctpd_pkg::RSTEPS) begin
        if (rs[i] >= t) begin
          rs[i+1] <= rs[i] - t;
          rr[i+1] <= (rr[i] >> 1) + bitv;
        end else begin
          rs[i+1] <= rs[i];
          rr[i+1] <= rr[i] >> 1;
        end
      end else begin
        rs[i+1] <= rs[i];
        rr[i+1] <= rr[i];
      end
    end
  end

  // finishing stage a: multiply for degrees, rounding, pi subtraction
  logic                 fa_v;
  logic                 fa_zr;
  logic                 fa_xn;
  logic                 fa_zneg;
  logic [63:0]          fa_prod;
  logic signed [ZW-1:0] fa_rad;
  logic [31:0]          fa_rad_o;
  logic [ZW-1:0]        zmag;
  logic signed [ZW:0]   tot;

  assign zmag = z[N][ZW-1] ? ZW'(-z[N]) : ZW'(z[N]);
  assign tot = xn[N] ? ((ZW+1)'(signed'({1'b0, ctpd_pkg::PI_Q30})) - (ZW+1)'(z[N]))
                     : (ZW+1)'(z[N]);

  always_ff @(posedge clk) begin
    if (rst) fa_v <= 1'b0;
    else fa_v <= v[N];
    fa_zr   <= zr[N];
    fa_xn   <= xn[N];
    fa_zneg <= z[N][ZW-1];
    fa_prod <= 64'(zmag[31:0]) * 64'(ctpd_pkg::DEG_Q24);
    fa_rad  <= ZW'((tot + (ZW+1)'(8192)) >>> 14);
    fa_rad_o <= (rr[N] < rs[N]) ? 32'(rr[N] + 64'd1) : 32'(rr[N]);
  end

  // finishing stage b: degree wrap and output register
  logic [9:0] dtr;
  logic [8:0] deg;
  assign dtr = 10'(fa_prod >> 54);

  always_comb begin
    if (!fa_xn) deg = (fa_zneg && dtr != 10'd0) ? 9'(10'd360 - dtr) : 9'(dtr);
    else deg = fa_zneg ? 9'(10'd180 + dtr) : 9'(10'd180 - dtr);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= fa_v;
    if (fa_zr) begin
      result <= '0;
    end else begin
      result.radius        <= fa_rad_o;
      result.angle_radians <= 20'(fa_rad);
      result.angle_degrees <= deg;
    end
  end

`ifndef ASSERT_OFF
  a_lat: assert property (@(posedge clk) disable iff (rst)
    v[N] |-> ##2 done)
    else $error("result lost in finishing stages");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    done |-> result.angle_degrees < 9'd360)
    else $error("degrees out of range");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    fa_v && fa_zr |=> result.radius == '0)
    else $error("zero vector gave nonzero radius");
`endif

endmodule

@@ sim/tb_cartesian_to_polar_degrees.sv @@
// tb_cartesian_to_polar_degrees: checks cartesian_to_polar_degrees against a behavioral
// cordic vectoring and rounded square root predictor, with random start gaps
// depends on ctpd_pkg and cartesian_to_polar_degrees
`timescale 1ns / 1ps
module tb_cartesian_to_polar_degrees;

  localparam int NITER = 20;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam longint DEG_Q24_L = 64'sd961263669;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  ctpd_pkg::in_item_t request = '0;
  logic busy;
  logic done;
  ctpd_pkg::out_item_t result;

  ctpd_pkg::in_item_t pending_requests[$];
  ctpd_pkg::out_item_t expected_polar[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  bit stim_done = 1'b0;
  bit gaps_on = 1'b1;

  cartesian_to_polar_degrees uut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  function automatic longint atan_step(int i);
    longint t[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return t[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic logic [63:0] rounded_root(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  function automatic ctpd_pkg::out_item_t polar_of(ctpd_pkg::in_item_t q);
    ctpd_pkg::out_item_t o;
    longint x, y, cx, cy, dx, dy, z, tot, rad, deg;
    logic [63:0] sq, mag;
    x = q.x_coord;
    y = q.y_coord;
    sq = x * x + y * y;
    o = '0;
    if (sq == 0) return o;
    cx = (x < 0 ? -x : x) <<< 28;
    cy = y <<< 28;
    z = 0;
    for (int i = 0; i < NITER; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += atan_step(i);
      end else begin
        cx -= dx; cy += dy; z -= atan_step(i);
      end
    end
    tot = (x >= 0) ? z : PI_Q30_L - z;
    rad = (tot + 8192) >>> 14;
    mag = (z < 0) ? -z : z;
    deg = longint'((mag * 64'(DEG_Q24_L)) >> 54);
    if (z < 0) deg = -deg;
    if (x >= 0) begin
      if (deg < 0) deg += 360;
    end else begin
      deg = 180 - deg;
    end
    o.radius = rounded_root(sq);
    o.angle_radians = rad[19:0];
    o.angle_degrees = deg[8:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 400)) - 200);
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      4: return 0;
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
    endcase
  endfunction

  initial begin
    logic signed [31:0] dv[10];
    ctpd_pkg::in_item_t q;
    dv = '{32'sh0, 32'sh1, -32'sh1, 32'sh10000, -32'sh10000, 32'sh7fffffff,
           32'sh80000000, 32'sh7fff, -32'sh12345, 32'sh5a827};
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        q.x_coord = dv[i * 2 % 10 + (i > 2)];
        q.y_coord = dv[j * 2 % 10 + (j > 2)];
        pending_requests.push_back(q);
      end
    end
    for (int i = 0; i < 800; i++) begin
      q.x_coord = rand_coord();
      q.y_coord = rand_coord();
      pending_requests.push_back(q);
    end
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 5) rst <= 1'b0;
    if (!rst) begin
      if (start && !busy) expected_polar.push_back(polar_of(request));
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        if (gaps_on && pending_requests.size() < 150) gaps_on = 1'b0;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 15);
          start <= 1'b0;
        end else begin
          request <= pending_requests.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ctpd_pkg::out_item_t e;
    if (!rst && done) begin
      if (expected_polar.size() == 0) begin
        report_mismatch("unexpected result radius", result.radius, 0);
      end else begin
        e = expected_polar.pop_front();
        if (result.radius !== e.radius)
          report_mismatch("radius", result.radius, e.radius);
        if (result.angle_radians !== e.angle_radians)
          report_mismatch("angle_radians", result.angle_radians, e.angle_radians);
        if (result.angle_degrees !== e.angle_degrees)
          report_mismatch("angle_degrees", result.angle_degrees, e.angle_degrees);
      end
    end
  end

  initial begin
    wait (stim_done);
    while ((pending_requests.size() > 0 || start || expected_polar.size() > 0)
           && cycles < LIMIT) @(posedge clk);
    repeat (60) @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("tb_cartesian_to_polar_degrees: FAIL");
    end else if (mismatches == 0 && expected_polar.size() == 0) begin
      $display("tb_cartesian_to_polar_degrees: PASS");
    end else begin
      $display("tb_cartesian_to_polar_degrees: FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/ctpd_pkg.sv
sv/ctpd_front.sv
sv/ctpd_queue.sv
sv/ctpd_back.sv
sv/cartesian_to_polar_degrees.sv
sim/tb_cartesian_to_polar_degrees.sv
